// ===== rtl/qsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qsg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIST_DEF   = 127;
  localparam int DELAY_BITS_DEF = 16;

  // Fixed field widths
  localparam int REQ_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam int MAX_DELAY_RST = 37500;
  localparam int MIN_DELAY_RST = 375;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 1'b1;

  // Command and direction codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;
  localparam logic DIR_POS  = 1'b0;
  localparam logic DIR_NEG  = 1'b1;

  // Phase codes and the steps that move the phase down or up by one
  localparam logic [1:0] PH_A_RISE = 2'd0;
  localparam logic [1:0] PH_B_RISE = 2'd1;
  localparam logic [1:0] PH_A_FALL = 2'd2;
  localparam logic [1:0] PH_B_FALL = 2'd3;
  localparam logic [1:0] PH_DOWN   = 2'd3;
  localparam logic [1:0] PH_UP     = 2'd1;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } qsg_div_st_t;

endpackage

`default_nettype wire

// ===== rtl/qsg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend shifts out
// of the top of the quotient register while quotient bits shift in below.
module qsg_div
  import qsg_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  parameter int RW         = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DELAY_BITS-1:0] dividend_i,
  input  wire logic [RW-1:0]         divisor_i,
  output qsg_div_st_t                st_o,
  output logic [DELAY_BITS-1:0]      quot_o
);

  localparam int CNT_W = $clog2(DELAY_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [RW-1:0]         dvs_q, dvs_d;
  logic [DELAY_BITS-1:0] quo_q, quo_d;

  logic [RW:0] trial;
  logic [RW:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[DELAY_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DELAY_BITS);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit of diff is spare
      rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_d = {quo_q[DELAY_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quot_o    = quo_q;

endmodule

`default_nettype wire

// ===== rtl/quadrature_step_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o   cmd_i, dir_i, dist_req_i
// out       source     out_valid_o/out_stall_i pin_a_o, pin_b_o, stepped_o, busy_res_o
// cfg       sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
// An item that takes no step, or takes the last step, does not start the divider.
// An item that steps with more than one step left starts the serial divider
// (max_delay / remaining steps including this one, one quotient bit per cycle);
// input stalls while the divider is busy and while its done flag is up.
// Input also stalls while the output register holds an item being stalled.
// Reset returns phase, lines, distance and wait to zero and the registers
// to their defaults.
module quadrature_step_generator
  import qsg_pkg::*;
#(
  parameter int MAX_DIST   = MAX_DIST_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [DELAY_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cmd_i,
  input  wire logic                  dir_i,
  input  wire logic [REQ_W-1:0]      dist_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       pin_a_o,
  output logic                       pin_b_o,
  output logic                       stepped_o,
  output logic                       busy_res_o
);

  localparam int RW    = $clog2(MAX_DIST + 1);
  localparam int CMP_W = (RW > REQ_W) ? RW : REQ_W;

  logic [DELAY_BITS-1:0] max_delay_q, min_delay_q;
  logic [RW-1:0]         remaining_q, remaining_d;
  logic [DELAY_BITS-1:0] wait_q, wait_d;
  logic [1:0]            phase_q, phase_d;
  logic                  direction_q, direction_d;
  logic                  level_a_q, level_a_d;
  logic                  level_b_q, level_b_d;
  logic                  out_valid_q;
  logic                  stepped_q, stepped_d;
  logic                  pin_a_q, pin_b_q, busy_res_q;

  logic                  accept;
  logic [RW-1:0]         dist_sat;
  logic [RW-1:0]         r;
  logic                  do_step;
  logic                  div_start;
  qsg_div_st_t           div_st;
  logic [DELAY_BITS-1:0] quot;

  assign in_stall_o = div_st.busy | div_st.done | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign dist_sat = (CMP_W'(dist_req_i) > CMP_W'(MAX_DIST)) ? RW'(MAX_DIST)
                                                           : RW'(dist_req_i);

  always_comb begin
    remaining_d = remaining_q;
    wait_d      = wait_q;
    phase_d     = phase_q;
    direction_d = direction_q;
    level_a_d   = level_a_q;
    level_b_d   = level_b_q;
    r           = remaining_q;
    do_step     = 1'b0;
    div_start   = 1'b0;

    if (div_st.done) begin
      // clamp the quotient at the shortest wait
      wait_d = (quot < min_delay_q) ? min_delay_q : quot;
    end else if (accept) begin
      if (cmd_i == CMD_LOAD) begin
        direction_d = dir_i;
        remaining_d = dist_sat;
        wait_d      = '0;
        r           = dist_sat;
        do_step     = (dist_sat != '0);
      end else if (remaining_q != '0) begin
        if (wait_q > DELAY_BITS'(1)) begin
          wait_d = wait_q - 1'b1;
        end else begin
          wait_d  = '0;
          do_step = 1'b1;
        end
      end

      if (do_step) begin
        phase_d = (direction_d == DIR_NEG) ? phase_q + PH_DOWN : phase_q + PH_UP;
        case (phase_d)
          PH_A_RISE: level_a_d = 1'b1;
          PH_B_RISE: level_b_d = 1'b1;
          PH_A_FALL: level_a_d = 1'b0;
          PH_B_FALL: level_b_d = 1'b0;
          default:   level_b_d = 1'b0;
        endcase
        remaining_d = r - 1'b1;
        wait_d      = '0;
        // no wait after the last step
        div_start   = (r > RW'(1));
      end
    end
  end

  assign stepped_d = do_step;

  qsg_div #(
    .DELAY_BITS (DELAY_BITS),
    .RW         (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (max_delay_q),
    .divisor_i  (r),
    .st_o       (div_st),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= DELAY_BITS'(MAX_DELAY_RST);
      min_delay_q <= DELAY_BITS'(MIN_DELAY_RST);
      remaining_q <= '0;
      wait_q      <= '0;
      phase_q     <= '0;
      direction_q <= DIR_POS;
      level_a_q   <= 1'b0;
      level_b_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_DELAY: max_delay_q <= cfg_data_i;
          REG_MIN_DELAY: min_delay_q <= cfg_data_i;
          default:       max_delay_q <= max_delay_q;
        endcase
      end
      remaining_q <= remaining_d;
      wait_q      <= wait_d;
      phase_q     <= phase_d;
      direction_q <= direction_d;
      level_a_q   <= level_a_d;
      level_b_q   <= level_b_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_a_q    <= level_a_d;
      pin_b_q    <= level_b_d;
      stepped_q  <= stepped_d;
      busy_res_q <= (remaining_d != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pin_a_o     = pin_a_q;
  assign pin_b_o     = pin_b_q;
  assign stepped_o   = stepped_q;
  assign busy_res_o  = busy_res_q;

endmodule

`default_nettype wire

// ===== rtl/qsg_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qsg_chk
  import qsg_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             cmd_i,
  input wire logic [REQ_W-1:0] dist_req_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             pin_a_o,
  input wire logic             pin_b_o,
  input wire logic             stepped_o,
  input wire logic             busy_res_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({pin_a_o, pin_b_o, stepped_o, busy_res_o}))
    else $error("stalled result changed");

  // every accepted item gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // a load of zero stops motion without a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD && dist_req_i == '0 |=>
      !stepped_o && !busy_res_o)
    else $error("load of zero stepped or stayed busy");

  // a load of a distance steps at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD && dist_req_i != '0 |=>
      stepped_o)
    else $error("load took no first step");

endmodule

bind quadrature_step_generator qsg_chk u_qsg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .dist_req_i  (dist_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pin_a_o     (pin_a_o),
  .pin_b_o     (pin_b_o),
  .stepped_o   (stepped_o),
  .busy_res_o  (busy_res_o)
);

`default_nettype wire
